### src/salc_pkg.sv
// Shared constants, beat types and tag RAM request type for the LRU tag cache.
`default_nettype none

package salc_pkg;

    // Geometry of the tag store
    localparam int MAX_SETS     = 256;
    localparam int MAX_WAYS     = 8;
    localparam int LINE_BYTES   = 64;
    localparam int STORE_DEPTH  = MAX_SETS * MAX_WAYS;

    localparam int ADDR_W       = 64;
    localparam int SIZE_W       = 7;
    localparam int CFG_W        = 4;
    localparam int OFFSET_BITS  = $clog2(LINE_BYTES);
    localparam int TAG_BITS     = ADDR_W - OFFSET_BITS;
    localparam int SET_BITS_MAX = $clog2(MAX_SETS);
    localparam int WAY_BITS     = $clog2(MAX_WAYS);
    localparam int WAY_CNT_BITS = $clog2(MAX_WAYS + 1);
    localparam int ENTRY_BITS   = $clog2(STORE_DEPTH);
    localparam int ROW_BITS     = ENTRY_BITS - WAY_BITS;
    localparam int ROWS         = STORE_DEPTH / MAX_WAYS;

    // Command codes
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Register indexes
    localparam logic REG_SET_INDEX_BITS = 1'b0;
    localparam logic REG_WAYS_IN_USE    = 1'b1;

    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [MAX_WAYS-1:0][TAG_BITS-1:0] tag_vec_t;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] access_size;
    } req_beat_t;

    typedef struct packed {
        logic hit;
        logic straddled;
    } rsp_beat_t;

    // Control for the banked tag RAM
    typedef struct packed {
        logic                    rd_en;
        logic                    wr_en;
        logic                    clr_en;
        logic [ENTRY_BITS-1:0]   base;
        logic [WAY_CNT_BITS-1:0] ways;
        logic [ROW_BITS-1:0]     clr_row;
    } ram_req_t;

endpackage

`default_nettype wire

### src/salc_tag_ram.sv
// Banked tag RAM: one bank per way slot, reads and writes a whole set per cycle.
`default_nettype none

module salc_tag_ram (
    input  wire logic               clk,
    input  wire salc_pkg::ram_req_t ram_req,
    input  wire salc_pkg::tag_vec_t wr_tags,
    output salc_pkg::tag_vec_t      rd_tags
);

    // Read data per bank and the rotation of the set that was read
    salc_pkg::tag_t                   rd_bank_reg [salc_pkg::MAX_WAYS];
    logic [salc_pkg::WAY_BITS-1:0]    rd_shift_reg;

    // Entry e lives in bank e[2:0], row e[10:3]; a set of consecutive
    // entries therefore touches every bank at most once.
    for (genvar b = 0; b < salc_pkg::MAX_WAYS; b++)
    begin : g_bank
        logic [salc_pkg::WAY_BITS-1:0]   way_sel;
        logic [salc_pkg::ENTRY_BITS-1:0] entry;
        logic [salc_pkg::ROW_BITS-1:0]   row;
        logic [salc_pkg::ROW_BITS-1:0]   wr_row;
        logic                            wr_en;
        salc_pkg::tag_t                  wr_data;
        salc_pkg::tag_t                  bank_mem [salc_pkg::ROWS];

        // Which way of the set falls in this bank, and at which row
        always_comb
        begin
            way_sel = salc_pkg::WAY_BITS'(b) - ram_req.base[salc_pkg::WAY_BITS-1:0];
            entry   = ram_req.base + salc_pkg::ENTRY_BITS'(way_sel);
            row     = entry[salc_pkg::ENTRY_BITS-1:salc_pkg::WAY_BITS];
            wr_en   = ram_req.clr_en
                    | (ram_req.wr_en
                       & (salc_pkg::WAY_CNT_BITS'(way_sel) < ram_req.ways));
            wr_row  = ram_req.clr_en ? ram_req.clr_row : row;
            wr_data = ram_req.clr_en ? '0 : wr_tags[way_sel];
        end

        // Bank storage, one write and one read port
        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                bank_mem[wr_row] <= wr_data;
            end
            if (ram_req.rd_en)
            begin
                rd_bank_reg[b] <= bank_mem[row];
            end
        end
    end

    // Remember rotation of the read set
    always_ff @(posedge clk)
    begin
        if (ram_req.rd_en)
        begin
            rd_shift_reg <= ram_req.base[salc_pkg::WAY_BITS-1:0];
        end
    end

    // Put read data back in way order
    always_comb
    begin
        for (int i = 0; i < salc_pkg::MAX_WAYS; i++)
        begin
            rd_tags[i] = rd_bank_reg[salc_pkg::WAY_BITS'(rd_shift_reg
                                                        + salc_pkg::WAY_BITS'(i))];
        end
    end

endmodule

`default_nettype wire

### src/set_assoc_lru_tag_cache_core.sv
// Set-associative tag-only cache with true LRU order per set, top level.
// Access: the address is split, then each set is read, compared and written back; both sets if it straddles.
// A new access is taken only in the idle state, once the last result is in the output register.
// Flush: the 256-row clearing sweep of the tag RAM, then an all-zero result.
// Reset: rst_n clears control registers and sets both configuration registers to 8; the same sweep then zeroes every
// tag while req_ready stays low; configuration writes are taken at any time.
`default_nettype none

module set_assoc_lru_tag_cache_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // access channel
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire salc_pkg::req_beat_t   req,
    // result channel
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output salc_pkg::rsp_beat_t        rsp,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_ISSUE,
        ST_CMP,
        ST_RESULT
    } state_t;

    // Control registers
    state_t                             state_reg;
    logic [salc_pkg::ROW_BITS-1:0]      clr_row_reg;
    logic                               flush_pend_reg;
    logic                               second_reg;
    logic                               rsp_valid_reg;
    salc_pkg::rsp_beat_t                rsp_reg;
    salc_pkg::rsp_beat_t                pend_reg;
    logic [salc_pkg::CFG_W-1:0]         set_index_bits_reg;
    logic [salc_pkg::CFG_W-1:0]         ways_in_use_reg;

    // Datapath registers
    salc_pkg::req_beat_t                item_reg;
    salc_pkg::tag_t                     tag1_reg;
    salc_pkg::tag_t                     tag2_reg;
    logic [salc_pkg::SET_BITS_MAX-1:0]  set1_reg;
    logic [salc_pkg::SET_BITS_MAX-1:0]  set2_reg;
    logic                               straddle_reg;
    logic                               hit_acc_reg;
    logic [salc_pkg::ENTRY_BITS-1:0]    base_reg;

    // Combinational signals
    logic [salc_pkg::CFG_W-1:0]         bits_eff;
    logic [salc_pkg::WAY_CNT_BITS-1:0]  ways_eff;
    logic [salc_pkg::SIZE_W-1:0]        size_m1;
    logic [salc_pkg::ADDR_W-1:0]        last_addr;
    salc_pkg::tag_t                     line1;
    salc_pkg::tag_t                     line2;
    logic [salc_pkg::SET_BITS_MAX-1:0]  set_mask;
    logic [salc_pkg::SET_BITS_MAX-1:0]  set1_c;
    logic [salc_pkg::SET_BITS_MAX-1:0]  set2_c;
    logic [salc_pkg::SET_BITS_MAX-1:0]  cur_set;
    logic [salc_pkg::ENTRY_BITS-1:0]    base_c;
    salc_pkg::tag_t                     cur_tag;
    salc_pkg::tag_vec_t                 old_tags;
    salc_pkg::tag_vec_t                 new_tags;
    logic [salc_pkg::WAY_BITS-1:0]      stop;
    logic                               found;
    logic                               hit_total;
    logic                               last_touch;
    logic                               rsp_free;
    logic                               rsp_load;
    logic                               cfg_write;
    salc_pkg::ram_req_t                 ram_req;

    // Effective configuration
    always_comb
    begin
        if (set_index_bits_reg > salc_pkg::CFG_W'(salc_pkg::SET_BITS_MAX))
        begin
            bits_eff = salc_pkg::CFG_W'(salc_pkg::SET_BITS_MAX);
        end
        else
        begin
            bits_eff = set_index_bits_reg;
        end
        if (ways_in_use_reg == '0)
        begin
            ways_eff = salc_pkg::WAY_CNT_BITS'(1);
        end
        else if (ways_in_use_reg > salc_pkg::CFG_W'(salc_pkg::MAX_WAYS))
        begin
            ways_eff = salc_pkg::WAY_CNT_BITS'(salc_pkg::MAX_WAYS);
        end
        else
        begin
            ways_eff = salc_pkg::WAY_CNT_BITS'(ways_in_use_reg);
        end
    end

    // Address split: first and last byte lines and their sets
    always_comb
    begin
        size_m1   = (item_reg.access_size == '0) ? '0
                  : item_reg.access_size - salc_pkg::SIZE_W'(1);
        last_addr = item_reg.address + salc_pkg::ADDR_W'(size_m1);
        line1     = item_reg.address[salc_pkg::ADDR_W-1:salc_pkg::OFFSET_BITS];
        line2     = last_addr[salc_pkg::ADDR_W-1:salc_pkg::OFFSET_BITS];
        set_mask  = ~({salc_pkg::SET_BITS_MAX{1'b1}} << bits_eff);
        set1_c    = line1[salc_pkg::SET_BITS_MAX-1:0] & set_mask;
        set2_c    = line2[salc_pkg::SET_BITS_MAX-1:0] & set_mask;
    end

    // Set base entry for the lookup being issued
    always_comb
    begin
        cur_set = second_reg ? set2_reg : set1_reg;
        cur_tag = second_reg ? tag2_reg : tag1_reg;
        base_c  = salc_pkg::ENTRY_BITS'(cur_set) * salc_pkg::ENTRY_BITS'(ways_eff);
    end

    // Way compare and LRU reorder
    always_comb
    begin
        logic [salc_pkg::MAX_WAYS-1:0] match;
        match = '0;
        stop  = salc_pkg::WAY_BITS'(ways_eff - salc_pkg::WAY_CNT_BITS'(1));
        found = 1'b0;
        for (int i = 0; i < salc_pkg::MAX_WAYS; i++)
        begin
            match[i] = (salc_pkg::WAY_CNT_BITS'(i) < ways_eff) && (old_tags[i] == cur_tag);
        end
        for (int i = salc_pkg::MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                stop  = salc_pkg::WAY_BITS'(i);
                found = 1'b1;
            end
        end
        new_tags[0] = cur_tag;
        for (int j = 1; j < salc_pkg::MAX_WAYS; j++)
        begin
            new_tags[j] = (salc_pkg::WAY_BITS'(j) <= stop) ? old_tags[j-1] : old_tags[j];
        end
    end

    assign hit_total  = second_reg ? (hit_acc_reg & found) : found;
    assign last_touch = !straddle_reg || second_reg;
    assign rsp_free   = !rsp_valid_reg || rsp_ready;

    // A result beat enters the output register this cycle
    assign rsp_load = rsp_free
                    && ((state_reg == ST_CLEAR && flush_pend_reg
                         && clr_row_reg == salc_pkg::ROW_BITS'(salc_pkg::ROWS - 1))
                        || (state_reg == ST_CMP && last_touch)
                        || state_reg == ST_RESULT);

    // Tag RAM requests by state
    always_comb
    begin
        ram_req         = '0;
        ram_req.ways    = ways_eff;
        ram_req.clr_row = clr_row_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.clr_en = 1'b1;
            end
            ST_ISSUE:
            begin
                ram_req.rd_en = 1'b1;
                ram_req.base  = base_c;
            end
            ST_CMP:
            begin
                ram_req.wr_en = 1'b1;
                ram_req.base  = base_reg;
            end
            default:
            begin
                ram_req.base = base_reg;
            end
        endcase
    end

    salc_tag_ram u_tag_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .wr_tags (new_tags),
        .rd_tags (old_tags)
    );

    // Configuration port
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[2])
            salc_pkg::REG_SET_INDEX_BITS: prdata = 32'(set_index_bits_reg);
            salc_pkg::REG_WAYS_IN_USE:    prdata = 32'(ways_in_use_reg);
            default:                      prdata = '0;
        endcase
    end

    // Sequencer, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clr_row_reg        <= '0;
            flush_pend_reg     <= 1'b0;
            second_reg         <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            rsp_reg            <= '0;
            pend_reg           <= '0;
            set_index_bits_reg <= salc_pkg::CFG_W'(8);
            ways_in_use_reg    <= salc_pkg::CFG_W'(8);
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[2])
                    salc_pkg::REG_SET_INDEX_BITS: set_index_bits_reg <= pwdata[salc_pkg::CFG_W-1:0];
                    salc_pkg::REG_WAYS_IN_USE:    ways_in_use_reg    <= pwdata[salc_pkg::CFG_W-1:0];
                    default:                      ;
                endcase
            end

            // Result valid: a new beat takes the register as the old one leaves
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + salc_pkg::ROW_BITS'(1);
                    if (clr_row_reg == salc_pkg::ROW_BITS'(salc_pkg::ROWS - 1))
                    begin
                        if (flush_pend_reg)
                        begin
                            flush_pend_reg <= 1'b0;
                            if (rsp_free)
                            begin
                                rsp_reg       <= '0;
                                state_reg     <= ST_IDLE;
                            end
                            else
                            begin
                                pend_reg  <= '0;
                                state_reg <= ST_RESULT;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        second_reg <= 1'b0;
                        if (req.command == salc_pkg::CMD_FLUSH)
                        begin
                            flush_pend_reg <= 1'b1;
                            clr_row_reg    <= '0;
                            state_reg      <= ST_CLEAR;
                        end
                        else
                        begin
                            state_reg <= ST_CALC;
                        end
                    end
                end
                ST_CALC:
                begin
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (last_touch)
                    begin
                        if (rsp_free)
                        begin
                            rsp_reg       <= '{hit: hit_total, straddled: straddle_reg};
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            pend_reg  <= '{hit: hit_total, straddled: straddle_reg};
                            state_reg <= ST_RESULT;
                        end
                    end
                    else
                    begin
                        second_reg <= 1'b1;
                        state_reg  <= ST_ISSUE;
                    end
                end
                ST_RESULT:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg       <= pend_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item capture, address split and lookup bookkeeping
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        if (state_reg == ST_CALC)
        begin
            set1_reg     <= set1_c;
            set2_reg     <= set2_c;
            tag1_reg     <= line1 >> bits_eff;
            tag2_reg     <= line2 >> bits_eff;
            straddle_reg <= (set1_c != set2_c);
        end
        if (state_reg == ST_ISSUE)
        begin
            base_reg <= base_c;
        end
        if (state_reg == ST_CMP)
        begin
            hit_acc_reg <= found;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Write-back always follows the read of the same set
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |-> $past(ram_req.rd_en) && ram_req.base == $past(ram_req.base))
        else $error("tag write-back not paired with the set read before it");

    // No access is taken while the clearing sweep runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |-> !ram_req.clr_en)
        else $error("access accepted during tag clearing sweep");

    // A result waiting in the output register is never overwritten
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("pending result overwritten or dropped");

    // A straddled result always comes from a two-set lookup
    a_straddle_two_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && straddle_reg && !second_reg) |=> state_reg == ST_ISSUE)
        else $error("second set lookup skipped on straddling access");

endmodule

`default_nettype wire

### verif/set_assoc_lru_tag_cache_core_tb.sv
// Self-checking testbench for the LRU tag cache core: directed and random access streams.
`default_nettype none

module set_assoc_lru_tag_cache_core_tb;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 123;
    localparam int DRAIN_CYCLES    = 20;

    // Register settings per random phase, extremes and out-of-range values included
    localparam logic [salc_pkg::CFG_W-1:0] PHASE_SET_BITS [PHASES] =
        '{4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd1, 4'd8, 4'd2, 4'd5, 4'd4};
    localparam logic [salc_pkg::CFG_W-1:0] PHASE_WAYS [PHASES] =
        '{4'd8, 4'd0, 4'd15, 4'd2, 4'd1, 4'd4, 4'd1, 4'd8, 4'd3, 4'd9};

    // Tag store mirror with true LRU order; holds the results each access must produce
    class lru_tag_tracker;
        salc_pkg::tag_t             tags [salc_pkg::STORE_DEPTH];
        logic [salc_pkg::CFG_W-1:0] set_bits_reg;
        logic [salc_pkg::CFG_W-1:0] ways_reg;
        salc_pkg::rsp_beat_t        expected_rsp [$];
        int                         mismatches;

        function new();
            foreach (tags[i]) tags[i] = '0;
            set_bits_reg = 4'd8;
            ways_reg     = 4'd8;
            mismatches   = 0;
        endfunction

        function void write_reg(input logic idx, input logic [salc_pkg::CFG_W-1:0] value);
            if (idx == salc_pkg::REG_SET_INDEX_BITS)
                set_bits_reg = value;
            else
                ways_reg = value;
        endfunction

        function int set_bits();
            return (set_bits_reg > salc_pkg::SET_BITS_MAX) ? salc_pkg::SET_BITS_MAX
                                                            : int'(set_bits_reg);
        endfunction

        function int ways();
            if (ways_reg == 0)
                return 1;
            return (ways_reg > salc_pkg::MAX_WAYS) ? salc_pkg::MAX_WAYS : int'(ways_reg);
        endfunction

        // Look up one set, move the tag to the front; returns 1 on a hit
        function bit promote(input int set_idx, input salc_pkg::tag_t tag, input int nways);
            int base;
            int stop;
            bit found;
            base  = set_idx * nways;
            stop  = nways - 1;
            found = 1'b0;
            for (int i = 0; i < nways; i++)
                if (!found && tags[base + i] == tag)
                begin
                    stop  = i;
                    found = 1'b1;
                end
            for (int j = stop; j > 0; j--)
                tags[base + j] = tags[base + j - 1];
            tags[base] = tag;
            return found;
        endfunction

        function void note_request(input salc_pkg::req_beat_t b);
            salc_pkg::rsp_beat_t         r;
            logic [salc_pkg::ADDR_W-1:0] last_byte;
            logic [salc_pkg::ADDR_W-1:0] line_a;
            logic [salc_pkg::ADDR_W-1:0] line_b;
            logic [salc_pkg::ADDR_W-1:0] mask;
            logic [salc_pkg::SIZE_W-1:0] size;
            int                          bits;
            int                          nways;
            int                          set_a;
            int                          set_b;
            bit                          hit_a;
            bit                          hit_b;
            r = '0;
            if (b.command == salc_pkg::CMD_FLUSH)
            begin
                foreach (tags[i]) tags[i] = '0;
            end
            else
            begin
                size      = (b.access_size == 0) ? 7'd1 : b.access_size;
                bits      = set_bits();
                nways     = ways();
                mask      = (64'd1 << bits) - 64'd1;
                last_byte = b.address + salc_pkg::ADDR_W'(size) - 64'd1;
                line_a    = b.address >> salc_pkg::OFFSET_BITS;
                line_b    = last_byte >> salc_pkg::OFFSET_BITS;
                set_a     = int'(line_a & mask);
                set_b     = int'(line_b & mask);
                if (set_a == set_b)
                    r.hit = promote(set_a, salc_pkg::tag_t'(line_a >> bits), nways);
                else
                begin
                    hit_a       = promote(set_a, salc_pkg::tag_t'(line_a >> bits), nways);
                    hit_b       = promote(set_b, salc_pkg::tag_t'(line_b >> bits), nways);
                    r.hit       = hit_a & hit_b;
                    r.straddled = 1'b1;
                end
            end
            expected_rsp.push_back(r);
        endfunction

        function void check_rsp(input salc_pkg::rsp_beat_t got);
            salc_pkg::rsp_beat_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("result beat with no access pending: hit=%0b straddled=%0b",
                       got.hit, got.straddled);
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0b, actual %0b", want.hit, got.hit);
                mismatches++;
            end
            if (got.straddled !== want.straddled)
            begin
                $error("straddled: expected %0b, actual %0b", want.straddled, got.straddled);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    salc_pkg::req_beat_t req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    salc_pkg::rsp_beat_t rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [2:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    lru_tag_tracker tracker;
    int             send_idle_pct = 13;
    int             recv_idle_pct = 50;
    int             quiet_cycles  = 0;

    set_assoc_lru_tag_cache_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random backpressure, check every accepted beat
    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
            tracker.check_rsp(rsp);

    // Watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Entered and left at a falling edge; valid stays up into the next beat
    task automatic send_beat(input salc_pkg::req_beat_t b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= b;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        tracker.note_request(b);
        @(negedge clk);
    endtask

    // Register write with a setup phase and then an enable phase
    task automatic write_reg(input logic idx, input logic [salc_pkg::CFG_W-1:0] value);
        logic [31:0] word;
        word = {28'($urandom_range(0, 32'h0FFF_FFFF)), value};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [salc_pkg::CFG_W-1:0] set_bits,
                              input logic [salc_pkg::CFG_W-1:0] nways);
        write_reg(salc_pkg::REG_SET_INDEX_BITS, set_bits);
        write_reg(salc_pkg::REG_WAYS_IN_USE, nways);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        req_valid <= 1'b0;
        while (tracker.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic salc_pkg::req_beat_t access_beat(
        input logic [salc_pkg::ADDR_W-1:0] addr,
        input logic [salc_pkg::SIZE_W-1:0] size);
        salc_pkg::req_beat_t b;
        b.command     = salc_pkg::CMD_ACCESS;
        b.address     = addr;
        b.access_size = size;
        return b;
    endfunction

    function automatic salc_pkg::req_beat_t flush_beat();
        salc_pkg::req_beat_t b;
        b.command     = salc_pkg::CMD_FLUSH;
        b.address     = {$urandom(), $urandom()};
        b.access_size = salc_pkg::SIZE_W'($urandom_range(0, 127));
        return b;
    endfunction

    // Mostly a small pool of lines per set so hits, misses and evictions all occur
    function automatic salc_pkg::req_beat_t random_access();
        salc_pkg::req_beat_t         b;
        logic [salc_pkg::ADDR_W-1:0] line;
        logic [salc_pkg::ADDR_W-1:0] mask;
        logic [salc_pkg::ADDR_W-1:0] set_pick;
        int                          bits;
        int                          pick;
        int                          size_pick;
        int                          offset;
        bits      = tracker.set_bits();
        mask      = (64'd1 << bits) - 64'd1;
        pick      = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 99);
        if (pick < 2)
            return flush_beat();
        if (size_pick < 60)
            b.access_size = salc_pkg::SIZE_W'($urandom_range(1, 8));
        else if (size_pick < 85)
            b.access_size = salc_pkg::SIZE_W'($urandom_range(1, 64));
        else
            b.access_size = salc_pkg::SIZE_W'($urandom_range(0, 127));
        b.command = salc_pkg::CMD_ACCESS;
        if (pick < 17)
            b.address = {$urandom(), $urandom()};
        else if (pick < 21)
            b.address = {{56{1'b1}}, 8'($urandom_range(0, 255))};
        else
        begin
            set_pick  = ($urandom_range(0, 3) == 0) ? mask : (64'($urandom_range(0, 2)) & mask);
            line      = (64'($urandom_range(0, tracker.ways() + 2)) << bits) | set_pick;
            offset    = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(56, 63);
            b.address = (line << salc_pkg::OFFSET_BITS) | salc_pkg::ADDR_W'(offset);
        end
        return b;
    endfunction

    initial
    begin
        tracker = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero tag after reset, address extremes, wrap, sizes, flush
        set_config(4'd8, 4'd8);
        send_beat(access_beat(64'h0, 7'd1));
        send_beat(access_beat('1, 7'd1));
        send_beat(access_beat('1, 7'd2));
        send_beat(access_beat(64'h40, 7'd0));
        send_beat(access_beat(64'h80, 7'd64));
        send_beat(access_beat(64'hC1, 7'd64));
        send_beat(access_beat(64'h13F, 7'd127));
        send_beat(access_beat(64'hC1, 7'd64));
        send_beat(access_beat(64'hAAAA_5555_AAAA_5555, 7'd1));
        send_beat(flush_beat());
        send_beat(access_beat(64'hC1, 7'd64));
        send_beat(access_beat(64'h5555_AAAA_5555_AAAA, 7'd127));
        settle();

        // Directed: one set, zero ways acting as one, two lines in the same set
        set_config(4'd0, 4'd0);
        send_beat(access_beat(64'h3F, 7'd2));
        send_beat(access_beat(64'h1000, 7'd1));
        send_beat(access_beat(64'h2000, 7'd1));
        send_beat(access_beat(64'h1000, 7'd1));
        send_beat(access_beat(64'h1000, 7'd1));

        // Random phases; odd phases keep the old tags across the config change
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            set_config(PHASE_SET_BITS[phase], PHASE_WAYS[phase]);
            if (phase < 4)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 50;
            end
            else if (phase < 7)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase % 2 == 0)
                send_beat(flush_beat());
            repeat (ITEMS_PER_PHASE) send_beat(random_access());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
src/salc_pkg.sv
src/salc_tag_ram.sv
src/set_assoc_lru_tag_cache_core.sv
verif/set_assoc_lru_tag_cache_core_tb.sv
